// ===== hdl/cb2_pkg.sv =====
package cb2_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// Angles are degrees with 24 fraction bits, sine and cosine have 30.
	localparam int ANG_FRAC  = 24;
	localparam int CS_FRAC   = 30;
	localparam int TABLE_LEN = 24;
	localparam int ZW        = 34;
	localparam int CW        = 33;

	localparam logic signed [CW-1:0] START_GAIN = 33'sd652032874;
	localparam logic signed [ZW-1:0] DEG90_Q24  = 34'sd1509949440;
	localparam logic signed [ZW-1:0] DEG180_Q24 = 34'sd3019898880;

	typedef enum logic {
		SHAPE_BOX    = 1'b0,
		SHAPE_CIRCLE = 1'b1
	} shape_t;

	typedef struct packed {
		shape_t              shape;
		logic signed [32:0]  px;
		logic signed [32:0]  py;
		logic [31:0]         bx;
		logic [31:0]         by;
		logic signed [31:0]  cex;
		logic signed [ZW-1:0] z;
	} item_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [32:0] v);
		logic [32:0] t;
		t = v[32] ? 33'(-v) : 33'(v);
		return t[31:0];
	endfunction

	function automatic logic [29:0] atan_q24(input int i);
		logic [29:0] r;
		unique case (i)
			0:  r = 30'd754974720;
			1:  r = 30'd445687602;
			2:  r = 30'd235489088;
			3:  r = 30'd119537938;
			4:  r = 30'd60000934;
			5:  r = 30'd30029717;
			6:  r = 30'd15018523;
			7:  r = 30'd7509720;
			8:  r = 30'd3754917;
			9:  r = 30'd1877466;
			10: r = 30'd938734;
			11: r = 30'd469367;
			12: r = 30'd234684;
			13: r = 30'd117342;
			14: r = 30'd58671;
			15: r = 30'd29335;
			16: r = 30'd14668;
			17: r = 30'd7334;
			18: r = 30'd3667;
			19: r = 30'd1833;
			20: r = 30'd917;
			21: r = 30'd458;
			22: r = 30'd229;
			23: r = 30'd115;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/cb2_front.sv =====
module cb2_front import cb2_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] angle_deg,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] half_x,
	input  logic signed [31:0] half_y,
	input  logic signed [31:0] radius,
	output logic               f_valid,
	input  logic               q_full,
	output item_t              f_item
);

	// One full turn, and a reciprocal that gives the turn count by a multiply.
	localparam logic [127:0] TURN = 128'd360 << FRAC_BITS;
	localparam int TB = $clog2(TURN);
	localparam int SH = TB + 31;
	localparam logic [127:0] RECIP = ((128'd1 << SH) / TURN) + 128'd1;
	localparam int QW = 35 - TB;
	localparam int RW = QW + TB + 3;
	localparam logic signed [TB+1:0] TURN_S = TURN[TB+1:0];
	localparam logic signed [RW-1:0] TURN_R = RW'(TURN);
	localparam logic signed [RW-1:0] HALF_R = RW'(TURN >> 1);
	localparam logic signed [32:0] RECIP_S = {1'b0, RECIP[31:0]};

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	shape_t             shape_s1, shape_s2, shape_s3;
	logic signed [31:0] ang_s1, ang_s2;
	logic signed [32:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic signed [64:0] prod_r_s1;
	logic signed [63:0] prod_a_s1, prod_b_s1;
	logic signed [QW+TB+1:0] qt_s2;
	logic signed [31:0] ma_s2, mb_s2, cex_s3;
	logic [31:0]        bx_s3, by_s3;
	logic signed [RW-1:0] r_s3;
	item_t              item_s4;

	logic signed [31:0] big;
	logic signed [63:0] sh_a, sh_b;
	logic signed [QW-1:0] q_c;
	logic signed [RW-1:0] r0, r1, rf;
	logic signed [ZW-1:0] z0, z1;

	assign rdy4 = !v_s4 || !q_full;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign f_valid = v_s4;
	assign f_item = item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign big = (scale_x > scale_y) ? scale_x : scale_y;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			shape_s1  <= shape_t'(cmd);
			ang_s1    <= angle_deg;
			px_s1     <= 33'(pos_x) + 33'(offset_x);
			py_s1     <= 33'(pos_y) + 33'(offset_y);
			prod_r_s1 <= 65'(angle_deg) * RECIP_S;
			prod_a_s1 <= (cmd == SHAPE_CIRCLE) ? 64'(big) * 64'(radius)
				: 64'(scale_x) * 64'(half_x);
			prod_b_s1 <= 64'(scale_y) * 64'(half_y);
		end
	end

	assign sh_a = prod_a_s1 >>> FRAC_BITS;
	assign sh_b = prod_b_s1 >>> FRAC_BITS;
	assign q_c  = QW'(prod_r_s1 >>> SH);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			shape_s2 <= shape_s1;
			ang_s2   <= ang_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			qt_s2    <= (QW+TB+2)'(q_c) * (QW+TB+2)'(TURN_S);
			ma_s2    <= sat32(66'(sh_a));
			mb_s2    <= sat32(66'(sh_b));
		end
	end

	// The reciprocal estimate of the turn count can be off by one either way.
	always_comb begin
		r0 = RW'(ang_s2) - RW'(qt_s2);
		if (r0 < 0) begin
			r1 = r0 + TURN_R;
		end else if (r0 >= TURN_R) begin
			r1 = r0 - TURN_R;
		end else begin
			r1 = r0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			shape_s3 <= shape_s2;
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			r_s3     <= r1;
			cex_s3   <= ma_s2;
			bx_s3    <= mag32(33'(ma_s2));
			by_s3    <= mag32(33'(mb_s2));
		end
	end

	// Fold to half a turn either side, then to within a quarter turn; the
	// sign change of sine and cosine this causes drops out in their magnitudes.
	always_comb begin
		rf = (r_s3 >= HALF_R) ? r_s3 - TURN_R : r_s3;
		z0 = ZW'(rf) <<< (ANG_FRAC - FRAC_BITS);
		if (z0 > DEG90_Q24) begin
			z1 = z0 - DEG180_Q24;
		end else if (z0 < -DEG90_Q24) begin
			z1 = z0 + DEG180_Q24;
		end else begin
			z1 = z0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			item_s4.shape <= shape_s3;
			item_s4.px    <= px_s3;
			item_s4.py    <= py_s3;
			item_s4.bx    <= bx_s3;
			item_s4.by    <= by_s3;
			item_s4.cex   <= cex_s3;
			item_s4.z     <= z1;
		end
	end

endmodule

// ===== hdl/cb2_queue.sv =====
module cb2_queue import cb2_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  nonempty,
	input  logic  pop,
	output item_t head
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [AW:0]   FULLC = (AW+1)'(DEPTH);

	item_t           mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push, do_pop;

	assign full     = (count_q == FULLC);
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== hdl/cb2_back.sv =====
module cb2_back import cb2_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nonempty,
	output logic               q_pop,
	input  item_t              q_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] min_x,
	output logic signed [31:0] min_y,
	output logic signed [31:0] max_x,
	output logic signed [31:0] max_y
);

	localparam int NS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int L  = NS + 4;
	localparam logic [34:0] EXT_MAX = 35'd2147483647;

	logic [L-1:0] vld_q;
	logic [L-1:0] rdy;

	logic signed [CW-1:0] x_s [NS+1];
	logic signed [CW-1:0] y_s [NS+1];
	logic signed [ZW-1:0] z_s [NS+1];
	item_t                it_s [NS+1];
	logic signed [CW-1:0] nx [NS+1];
	logic signed [CW-1:0] ny [NS+1];
	logic signed [ZW-1:0] nz [NS+1];

	item_t              it_sm, it_sx;
	logic [63:0]        p0_sm, p1_sm, p2_sm, p3_sm;
	logic signed [31:0] ex_sx, ey_sx;
	logic [31:0]        cmag, smag;
	logic [34:0]        hx, hy;
	logic signed [31:0] ex_c, ey_c;
	logic signed [31:0] min_x_q, min_y_q, max_x_q, max_y_q;

	assign rdy[L-1] = !vld_q[L-1] || !out_stall;
	for (genvar k = 0; k < L - 1; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign q_pop     = q_nonempty && rdy[0];
	assign out_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= q_nonempty;
			for (int k = 1; k < L; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// One rotation step per stage, turning toward zero residual angle.
	always_comb begin
		nx[0] = START_GAIN;
		ny[0] = '0;
		nz[0] = q_item.z;
		for (int k = 0; k < NS; k++) begin
			if (z_s[k] >= 0) begin
				nx[k+1] = x_s[k] - (y_s[k] >>> k);
				ny[k+1] = y_s[k] + (x_s[k] >>> k);
				nz[k+1] = z_s[k] - ZW'(atan_q24(k));
			end else begin
				nx[k+1] = x_s[k] + (y_s[k] >>> k);
				ny[k+1] = y_s[k] - (x_s[k] >>> k);
				nz[k+1] = z_s[k] + ZW'(atan_q24(k));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			x_s[0]  <= nx[0];
			y_s[0]  <= ny[0];
			z_s[0]  <= nz[0];
			it_s[0] <= q_item;
		end
		for (int k = 1; k <= NS; k++) begin
			if (rdy[k]) begin
				x_s[k]  <= nx[k];
				y_s[k]  <= ny[k];
				z_s[k]  <= nz[k];
				it_s[k] <= it_s[k-1];
			end
		end
	end

	assign cmag = mag32(x_s[NS]);
	assign smag = mag32(y_s[NS]);

	always_ff @(posedge clk) begin
		if (rdy[NS+1]) begin
			it_sm <= it_s[NS];
			p0_sm <= 64'(it_s[NS].bx) * 64'(cmag);
			p1_sm <= 64'(it_s[NS].by) * 64'(smag);
			p2_sm <= 64'(it_s[NS].bx) * 64'(smag);
			p3_sm <= 64'(it_s[NS].by) * 64'(cmag);
		end
	end

	always_comb begin
		hx = 35'((65'(p0_sm) + 65'(p1_sm)) >> CS_FRAC);
		hy = 35'((65'(p2_sm) + 65'(p3_sm)) >> CS_FRAC);
		if (it_sm.shape == SHAPE_CIRCLE) begin
			ex_c = it_sm.cex;
			ey_c = it_sm.cex;
		end else begin
			ex_c = (hx > EXT_MAX) ? 32'sh7FFFFFFF : hx[31:0];
			ey_c = (hy > EXT_MAX) ? 32'sh7FFFFFFF : hy[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NS+2]) begin
			it_sx <= it_sm;
			ex_sx <= ex_c;
			ey_sx <= ey_c;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NS+3]) begin
			min_x_q <= sat32(66'(it_sx.px) - 66'(ex_sx));
			min_y_q <= sat32(66'(it_sx.py) - 66'(ey_sx));
			max_x_q <= sat32(66'(it_sx.px) + 66'(ex_sx));
			max_y_q <= sat32(66'(it_sx.py) + 66'(ey_sx));
		end
	end

	assign min_x = min_x_q;
	assign min_y = min_y_q;
	assign max_x = max_x_q;
	assign max_y = max_y_q;

endmodule

// ===== hdl/collider_bounds_2d.sv =====
// Axis-aligned bounds of one 2D collider per beat, all values signed fixed point
// with FRAC_BITS fraction bits. A box is scaled, rotated by the angle through a
// pipelined CORDIC and bounded; a circle uses the larger scale times its radius.
// One beat is accepted every cycle when the output is not stalled. A result beat
// passes 4 front stages (turn reduction by reciprocal multiply, products), is
// registered in the queue, then passes min(CORDIC_STEPS, 24) + 4 back stages, the
// CORDIC steps setting the depth. While the output is held the input keeps
// accepting until the front, the queue and the back stages are all full,
// QUEUE_DEPTH + min(CORDIC_STEPS, 24) + 8 beats in all, and only then stalls.
module collider_bounds_2d import cb2_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] angle_deg,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] half_x,
	input  logic signed [31:0] half_y,
	input  logic signed [31:0] radius,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] min_x,
	output logic signed [31:0] min_y,
	output logic signed [31:0] max_x,
	output logic signed [31:0] max_y
);

	logic  f_valid, q_full, q_nonempty, q_pop;
	item_t f_item, q_head;

	cb2_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .pos_x, .pos_y,
		.scale_x, .scale_y, .angle_deg, .offset_x, .offset_y,
		.half_x, .half_y, .radius,
		.f_valid, .q_full, .f_item
	);

	cb2_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.push(f_valid), .push_item(f_item), .full(q_full),
		.nonempty(q_nonempty), .pop(q_pop), .head(q_head)
	);

	cb2_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .q_nonempty, .q_pop, .q_item(q_head),
		.out_valid, .out_stall, .min_x, .min_y, .max_x, .max_y
	);

endmodule

// ===== verif/collider_bounds_2d_tb.sv =====
module collider_bounds_2d_tb;
	import cb2_pkg::*;

	localparam int FRAC       = 16;
	localparam int STEPS      = 16;
	localparam int LIMIT      = 400000;
	localparam int HOLD_START = 400;
	localparam int HOLD_LEN   = 200;
	localparam int CALM_START = 1000;
	localparam int CALM_END   = 1400;
	localparam longint TURN   = 360 * 65536;

	localparam longint ATAN_DEG[24] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	typedef struct {
		shape_t             shape;
		logic signed [31:0] pos_x, pos_y, scale_x, scale_y, angle_deg;
		logic signed [31:0] offset_x, offset_y, half_x, half_y, radius;
	} collider_t;

	typedef struct {
		logic signed [31:0] min_x, min_y, max_x, max_y;
	} bounds_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 1;
	logic in_stall, out_valid;
	logic signed [31:0] min_x, min_y, max_x, max_y;
	collider_t cur = '{SHAPE_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

	collider_t pending[$];
	bounds_t   expected_bounds[$];
	int cyc = 0;
	int errors = 0;
	int n_box = 0;
	int n_circle = 0;
	int n_checked = 0;

	collider_bounds_2d dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cur.shape), .pos_x(cur.pos_x), .pos_y(cur.pos_y),
		.scale_x(cur.scale_x), .scale_y(cur.scale_y), .angle_deg(cur.angle_deg),
		.offset_x(cur.offset_x), .offset_y(cur.offset_y),
		.half_x(cur.half_x), .half_y(cur.half_y), .radius(cur.radius),
		.out_valid(out_valid), .out_stall(out_stall),
		.min_x(min_x), .min_y(min_y), .max_x(max_x), .max_y(max_y)
	);

	always #4 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = a * b;
		return clamp32(p >>> FRAC);
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// Folds the angle into [-90, 90] degrees and runs the CORDIC rotation.
	function automatic void cordic_sin_cos(longint ang, output longint c, output longint s);
		longint r, x, y, z, dx, dy;
		bit flip;
		r = ang % TURN;
		x = 652032874;
		y = 0;
		flip = 0;
		if (r < 0) r += TURN;
		if (r >= TURN / 2) r -= TURN;
		z = r * 256;
		if (z > 64'sd1509949440) begin
			z -= 64'sd3019898880;
			flip = 1;
		end else if (z < -64'sd1509949440) begin
			z += 64'sd3019898880;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_DEG[i];
			end else begin
				x += dx; y -= dy; z += ATAN_DEG[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic bounds_t bounds_of(collider_t a);
		bounds_t b;
		longint cx, cy, ex, ey, c, s, big;
		longint unsigned bx, by, hx, hy;
		cx = longint'(a.pos_x) + longint'(a.offset_x);
		cy = longint'(a.pos_y) + longint'(a.offset_y);
		if (a.shape == SHAPE_BOX) begin
			bx = magnitude(fx_mul(a.scale_x, a.half_x));
			by = magnitude(fx_mul(a.scale_y, a.half_y));
			cordic_sin_cos(a.angle_deg, c, s);
			hx = (bx * magnitude(c) + by * magnitude(s)) >> 30;
			hy = (bx * magnitude(s) + by * magnitude(c)) >> 30;
			ex = hx > 64'd2147483647 ? 64'sd2147483647 : longint'(hx);
			ey = hy > 64'd2147483647 ? 64'sd2147483647 : longint'(hy);
		end else begin
			big = a.scale_x > a.scale_y ? longint'(a.scale_x) : longint'(a.scale_y);
			ex = fx_mul(big, a.radius);
			ey = ex;
		end
		b.min_x = 32'(clamp32(cx - ex));
		b.min_y = 32'(clamp32(cy - ey));
		b.max_x = 32'(clamp32(cx + ex));
		b.max_y = 32'(clamp32(cy + ey));
		return b;
	endfunction

	function automatic logic signed [31:0] any32();
		return $urandom();
	endfunction

	// Mostly plausible game-scale values, with a share of raw 32-bit patterns.
	function automatic logic signed [31:0] fx_val(int lo, int hi);
		if ($urandom_range(99) < 20) return any32();
		return ($urandom_range(hi - lo) + lo) * 256;
	endfunction

	function automatic collider_t random_collider();
		collider_t a;
		a.shape     = $urandom_range(1) ? SHAPE_CIRCLE : SHAPE_BOX;
		a.pos_x     = fx_val(-256000, 256000);
		a.pos_y     = fx_val(-256000, 256000);
		a.scale_x   = fx_val(-256, 1024);
		a.scale_y   = fx_val(-256, 1024);
		a.angle_deg = fx_val(-184320, 184320);
		a.offset_x  = fx_val(-2560, 2560);
		a.offset_y  = fx_val(-2560, 2560);
		a.half_x    = fx_val(-256, 25600);
		a.half_y    = fx_val(-256, 25600);
		a.radius    = fx_val(-256, 25600);
		return a;
	endfunction

	function automatic collider_t shaped(shape_t sh, int ang, int sx, int sy,
			int hx, int hy, int rad, int pos);
		collider_t a;
		a = '{sh, pos, pos, sx, sy, ang, 32'sh10000, -32'sh10000, hx, hy, rad};
		return a;
	endfunction

	function automatic bit sender_idle();
		if (cyc >= CALM_START && cyc < CALM_END) return 0;
		return $urandom_range(99) < 38;
	endfunction

	// Sender side: predict on acceptance, then present the next beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_bounds.push_back(bounds_of(cur));
				if (cur.shape == SHAPE_BOX) n_box++;
				else n_circle++;
			end
			if (!in_valid || !in_stall) begin
				if (pending.size() > 0 && !sender_idle()) begin
					cur <= pending.pop_front();
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Receiver side: check each result beat and choose the next stall.
	always @(posedge clk or negedge arst_n) begin
		bounds_t e;
		if (!arst_n) begin
			out_stall <= 1;
		end else begin
			cyc++;
			if (cyc > LIMIT) begin
				$display("[collider_bounds_2d] ERROR");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (expected_bounds.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = expected_bounds.pop_front();
					n_checked++;
					if (min_x !== e.min_x) begin
						$error("min_x expected %0d got %0d", e.min_x, min_x); errors++;
					end
					if (min_y !== e.min_y) begin
						$error("min_y expected %0d got %0d", e.min_y, min_y); errors++;
					end
					if (max_x !== e.max_x) begin
						$error("max_x expected %0d got %0d", e.max_x, max_x); errors++;
					end
					if (max_y !== e.max_y) begin
						$error("max_y expected %0d got %0d", e.max_y, max_y); errors++;
					end
				end
			end
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) out_stall <= 1;
			else if (cyc >= CALM_START && cyc < CALM_END) out_stall <= 0;
			else out_stall <= $urandom_range(99) < 38;
		end
	end

	initial begin
		int one;
		one = 32'sh10000;
		// Axis angles, wrap points of the turn and the largest raw angles.
		pending.push_back(shaped(SHAPE_BOX, 0, one, one, 3 * one, one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, 90 * one, one, one, 3 * one, one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, -90 * one, one, one, 3 * one, one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, 180 * one, one, one, 3 * one, one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, -180 * one, one, one, 3 * one, one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, 270 * one, 2 * one, one, one, 5 * one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, 45 * one, one, one, one, one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, 135 * one, one, one, one, 2 * one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, 32'sh7FFFFFFF, one, one, one, one, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, 32'sh80000000, one, one, one, one, 0, 0));
		// Negative extents and scales on a box fold to absolute values.
		pending.push_back(shaped(SHAPE_BOX, 30 * one, -one, one, -2 * one, 4 * one, 0, 0));
		// Saturating products and overflowing corners.
		pending.push_back(shaped(SHAPE_BOX, 30 * one, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh80000000, 0, 0));
		pending.push_back(shaped(SHAPE_BOX, 0, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 0, 32'sh7FFFFFFF));
		pending.push_back(shaped(SHAPE_BOX, 45 * one, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 32'sh80000000));
		// Circles: plain, negative radius or scale, saturation both ways.
		pending.push_back(shaped(SHAPE_CIRCLE, 0, one, 2 * one, 0, 0, 3 * one, 0));
		pending.push_back(shaped(SHAPE_CIRCLE, 0, one, one, 0, 0, -3 * one, 0));
		pending.push_back(shaped(SHAPE_CIRCLE, 0, -one, -2 * one, 0, 0, 3 * one, 0));
		pending.push_back(shaped(SHAPE_CIRCLE, 0, 32'sh80000000, 32'sh80000000, 0, 0,
			32'sh80000000, 0));
		pending.push_back(shaped(SHAPE_CIRCLE, 0, 32'sh7FFFFFFF, 0, 0, 0,
			32'sh7FFFFFFF, 32'sh7FFFFFFF));
		pending.push_back(shaped(SHAPE_CIRCLE, 0, 32'sh7FFFFFFF, 0, 0, 0,
			32'sh80000000, 32'sh80000000));
		pending.push_back(shaped(SHAPE_CIRCLE, 77 * one, 0, 0, -1, -1, 0, -1));
		repeat (1150) pending.push_back(random_collider());

		repeat (6) @(posedge clk);
		arst_n <= 1;
		wait (pending.size() == 0 && !in_valid && expected_bounds.size() == 0);
		repeat (100) @(posedge clk);
		$display("Checked %0d result beats from %0d boxes and %0d circles,", n_checked,
			n_box, n_circle);
		$display("including angle wraps, saturation and a long output hold-off.");
		if (errors == 0 && expected_bounds.size() == 0)
			$display("[collider_bounds_2d] OK");
		else
			$display("[collider_bounds_2d] ERROR");
		$finish;
	end
endmodule
